>>> hw/rtl/msp_pkg.sv
package msp_pkg;

	localparam int SAMPLE_BITS_DEF = 12;
	localparam int COUNT_BITS_DEF  = 17;

	localparam int CHAN_BITS   = 3;
	localparam int ZERO_BITS   = 12;
	localparam int SCALE_BITS  = 20;
	localparam int GAIN_BITS   = 2;
	localparam int VALUE_BITS  = 7;
	localparam int TUBE_BITS   = 8;
	localparam int FRAC_BITS   = 32;
	localparam int ROUND_SHIFT = FRAC_BITS - 1;
	localparam int SHIFT_BITS  = 3;

	localparam int APB_ADDR_BITS = 5;
	localparam int APB_DATA_BITS = 32;
	localparam int REG_IDX_BITS  = 3;

	localparam logic [REG_IDX_BITS-1:0] REG_SAMPLE_CHANNEL = 3'd0;
	localparam logic [REG_IDX_BITS-1:0] REG_ZERO_CODE      = 3'd1;
	localparam logic [REG_IDX_BITS-1:0] REG_SCALE_Q32      = 3'd2;
	localparam logic [REG_IDX_BITS-1:0] REG_GAIN_MODE      = 3'd3;
	localparam logic [REG_IDX_BITS-1:0] REG_TEST_MODE      = 3'd4;

	localparam logic [CHAN_BITS-1:0]  RST_SAMPLE_CHANNEL = 3'd5;
	localparam logic [ZERO_BITS-1:0]  RST_ZERO_CODE      = 12'd2275;
	localparam logic [SCALE_BITS-1:0] RST_SCALE_Q32      = 20'd46688;
	localparam logic [GAIN_BITS-1:0]  RST_GAIN_MODE      = 2'd0;

	localparam logic [GAIN_BITS-1:0] GAIN_X4 = 2'd0;
	localparam logic [GAIN_BITS-1:0] GAIN_X8 = 2'd1;

	localparam logic [VALUE_BITS-1:0] DISPLAY_MAX = 7'd99;
	localparam logic [VALUE_BITS-1:0] DISPLAY_SPAN = 7'd100;

	typedef struct packed {
		logic [CHAN_BITS-1:0]  sample_channel;
		logic [ZERO_BITS-1:0]  zero_code;
		logic [SCALE_BITS-1:0] scale_q32;
		logic [GAIN_BITS-1:0]  gain_mode;
		logic                  test_mode;
		logic                  test_restart;
	} cfg_t;

	typedef struct packed {
		logic                  take;
		logic                  square;
		logic                  accum;
		logic                  mul_lo;
		logic                  mul_hi;
		logic                  combine;
		logic                  scale;
		logic                  check;
		logic                  div_step;
		logic [SHIFT_BITS-1:0] div_bit;
		logic                  value_init;
		logic                  finish;
	} cmd_t;

	typedef struct packed {
		logic item_valid;
		logic is_tick;
		logic chan_hit;
		logic test_mode;
		logic count_zero;
		logic over;
		logic out_free;
	} sts_t;

	function automatic logic [SHIFT_BITS-1:0] gain_shift(input logic [GAIN_BITS-1:0] mode);
		logic [SHIFT_BITS-1:0] s;
		if (mode == GAIN_X4)
			s = 3'd2;
		else if (mode == GAIN_X8)
			s = 3'd3;
		else
			s = 3'd4;
		return s;
	endfunction

	// {byte one, byte two, byte three} for a value of 0..99
	function automatic logic [3*TUBE_BITS-1:0] tube_bytes(input logic [VALUE_BITS-1:0] v);
		logic [3:0]            tens;
		logic [VALUE_BITS-1:0] ones_w;
		logic [3:0]            ones;
		logic [TUBE_BITS-1:0]  b1;
		logic [TUBE_BITS-1:0]  b2;
		logic [TUBE_BITS-1:0]  b3;
		tens = 4'd0;
		for (int i = 1; i <= 9; i++) begin
			if (v >= VALUE_BITS'(10 * i))
				tens = tens + 4'd1;
		end
		ones_w = v - (VALUE_BITS'(tens) * VALUE_BITS'(10));
		ones = ones_w[3:0];
		b1 = '0;
		b2 = '0;
		b3 = '0;
		if (tens >= 4'd1 && tens <= 4'd7)
			b1[tens[2:0]] = 1'b1;
		else if (tens == 4'd8)
			b2[1] = 1'b1;
		else if (tens == 4'd9)
			b2[2] = 1'b1;
		else
			b2[3] = 1'b1;
		if (ones >= 4'd1 && ones <= 4'd4)
			b2[3'(ones + 4'd3)] = 1'b1;
		else if (ones >= 4'd5)
			b3[3'(ones - 4'd4)] = 1'b1;
		else
			b3[6] = 1'b1;
		return {b1, b2, b3};
	endfunction

endpackage

>>> hw/rtl/msp_if.sv
interface msp_item_if #(parameter int SAMPLE_BITS = msp_pkg::SAMPLE_BITS_DEF);
	logic                           valid;
	logic                           ready;
	logic                           req_type;
	logic [msp_pkg::CHAN_BITS-1:0]  sample_channel_id;
	logic [SAMPLE_BITS-1:0]         sample_code;

	modport source(output valid, req_type, sample_channel_id, sample_code, input ready);
	modport sink(input valid, req_type, sample_channel_id, sample_code, output ready);
endinterface

interface msp_result_if;
	logic                           valid;
	logic                           ready;
	logic [msp_pkg::VALUE_BITS-1:0] display_value;
	logic [msp_pkg::TUBE_BITS-1:0]  tube_byte_one;
	logic [msp_pkg::TUBE_BITS-1:0]  tube_byte_two;
	logic [msp_pkg::TUBE_BITS-1:0]  tube_byte_three;
	logic                           saturated;

	modport source(output valid, display_value, tube_byte_one, tube_byte_two, tube_byte_three,
		saturated, input ready);
	modport sink(input valid, display_value, tube_byte_one, tube_byte_two, tube_byte_three,
		saturated, output ready);
endinterface

>>> hw/rtl/msp_regs.sv
module msp_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [msp_pkg::APB_ADDR_BITS-1:0] paddr,
	input  logic [msp_pkg::APB_DATA_BITS-1:0] pwdata,
	output logic [msp_pkg::APB_DATA_BITS-1:0] prdata,
	output logic                              pready,
	output msp_pkg::cfg_t                     cfg
);

	logic [msp_pkg::CHAN_BITS-1:0]    sample_channel_q;
	logic [msp_pkg::ZERO_BITS-1:0]    zero_code_q;
	logic [msp_pkg::SCALE_BITS-1:0]   scale_q32_q;
	logic [msp_pkg::GAIN_BITS-1:0]    gain_mode_q;
	logic                             test_mode_q;
	logic                             wr;
	logic [msp_pkg::REG_IDX_BITS-1:0] idx;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite && pready;
	assign idx    = paddr[msp_pkg::APB_ADDR_BITS-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_channel_q <= msp_pkg::RST_SAMPLE_CHANNEL;
			zero_code_q      <= msp_pkg::RST_ZERO_CODE;
			scale_q32_q      <= msp_pkg::RST_SCALE_Q32;
			gain_mode_q      <= msp_pkg::RST_GAIN_MODE;
			test_mode_q      <= 1'b0;
		end else if (wr) begin
			unique case (idx)
				msp_pkg::REG_SAMPLE_CHANNEL: sample_channel_q <= pwdata[msp_pkg::CHAN_BITS-1:0];
				msp_pkg::REG_ZERO_CODE:      zero_code_q      <= pwdata[msp_pkg::ZERO_BITS-1:0];
				msp_pkg::REG_SCALE_Q32:      scale_q32_q      <= pwdata[msp_pkg::SCALE_BITS-1:0];
				msp_pkg::REG_GAIN_MODE:      gain_mode_q      <= pwdata[msp_pkg::GAIN_BITS-1:0];
				msp_pkg::REG_TEST_MODE:      test_mode_q      <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			msp_pkg::REG_SAMPLE_CHANNEL: prdata = msp_pkg::APB_DATA_BITS'(sample_channel_q);
			msp_pkg::REG_ZERO_CODE:      prdata = msp_pkg::APB_DATA_BITS'(zero_code_q);
			msp_pkg::REG_SCALE_Q32:      prdata = msp_pkg::APB_DATA_BITS'(scale_q32_q);
			msp_pkg::REG_GAIN_MODE:      prdata = msp_pkg::APB_DATA_BITS'(gain_mode_q);
			msp_pkg::REG_TEST_MODE:      prdata = msp_pkg::APB_DATA_BITS'(test_mode_q);
			default:                     prdata = '0;
		endcase
	end

	always_comb begin
		cfg.sample_channel = sample_channel_q;
		cfg.zero_code      = zero_code_q;
		cfg.scale_q32      = scale_q32_q;
		cfg.gain_mode      = gain_mode_q;
		cfg.test_mode      = test_mode_q;
		// restart the test counter when test mode turns on
		cfg.test_restart   = wr && (idx == msp_pkg::REG_TEST_MODE) && pwdata[0] && !test_mode_q;
	end

endmodule

>>> hw/rtl/msp_ctrl.sv
module msp_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  msp_pkg::sts_t sts,
	output msp_pkg::cmd_t cmd
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LATCH,
		ST_SQUARE,
		ST_ACCUM,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_COMBINE,
		ST_SCALE,
		ST_CHECK,
		ST_DIVIDE,
		ST_FINISH
	} state_t;

	localparam logic [msp_pkg::SHIFT_BITS-1:0] TOP_BIT = msp_pkg::SHIFT_BITS'(msp_pkg::VALUE_BITS - 1);

	state_t                        state_q;
	logic [msp_pkg::SHIFT_BITS-1:0] step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (sts.item_valid)
						state_q <= ST_LATCH;
				end
				ST_LATCH: begin
					priority if (!sts.is_tick)
						state_q <= sts.chan_hit ? ST_SQUARE : ST_IDLE;
					else if (sts.test_mode || sts.count_zero)
						state_q <= ST_FINISH;
					else
						state_q <= ST_MUL_LO;
				end
				ST_SQUARE:  state_q <= ST_ACCUM;
				ST_ACCUM:   state_q <= ST_IDLE;
				ST_MUL_LO:  state_q <= ST_MUL_HI;
				ST_MUL_HI:  state_q <= ST_COMBINE;
				ST_COMBINE: state_q <= ST_SCALE;
				ST_SCALE:   state_q <= ST_CHECK;
				ST_CHECK: begin
					step_q <= TOP_BIT;
					state_q <= sts.over ? ST_FINISH : ST_DIVIDE;
				end
				ST_DIVIDE: begin
					if (step_q == '0)
						state_q <= ST_FINISH;
					else
						step_q <= step_q - 1'b1;
				end
				ST_FINISH: begin
					if (sts.out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd            = '0;
		cmd.take       = (state_q == ST_IDLE);
		cmd.square     = (state_q == ST_SQUARE);
		cmd.accum      = (state_q == ST_ACCUM);
		cmd.mul_lo     = (state_q == ST_MUL_LO);
		cmd.mul_hi     = (state_q == ST_MUL_HI);
		cmd.combine    = (state_q == ST_COMBINE);
		cmd.scale      = (state_q == ST_SCALE);
		cmd.check      = (state_q == ST_CHECK);
		cmd.div_step   = (state_q == ST_DIVIDE);
		cmd.div_bit    = step_q;
		cmd.value_init = (state_q == ST_LATCH) && sts.is_tick;
		cmd.finish     = (state_q == ST_FINISH) && sts.out_free;
	end

endmodule

>>> hw/rtl/msp_dp.sv
module msp_dp #(
	parameter int SAMPLE_BITS = msp_pkg::SAMPLE_BITS_DEF,
	parameter int COUNT_BITS  = msp_pkg::COUNT_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  msp_pkg::cfg_t cfg,
	input  msp_pkg::cmd_t cmd,
	output msp_pkg::sts_t sts,
	msp_item_if.sink      item,
	msp_result_if.source  result
);

	localparam int SQ_BITS    = 2 * SAMPLE_BITS;
	localparam int SUM_BITS   = SQ_BITS + COUNT_BITS;
	localparam int SUM_EXT    = SUM_BITS + 1;
	localparam int SPLIT_BITS = (SUM_BITS + 1) / 2;
	localparam int MUL_BITS   = SPLIT_BITS + msp_pkg::SCALE_BITS;
	localparam int PROD_BITS  = SUM_BITS + msp_pkg::SCALE_BITS;
	localparam int FULL_BITS  = PROD_BITS + 5;
	localparam int NUM_BITS   = FULL_BITS - msp_pkg::FRAC_BITS;
	localparam int REM_BITS   = COUNT_BITS + msp_pkg::VALUE_BITS;
	localparam int VB         = msp_pkg::VALUE_BITS;
	localparam int TB         = msp_pkg::TUBE_BITS;

	// accumulators and control state
	logic [SUM_BITS-1:0]   sum_q;
	logic [COUNT_BITS-1:0] count_q;
	logic                  ovf_q;
	logic [VB-1:0]         test_q;
	logic                  res_valid_q;

	// working registers
	logic                   tick_q;
	logic                   hit_q;
	logic [SAMPLE_BITS-1:0] diff_q;
	logic [SQ_BITS-1:0]     sq_q;
	logic [MUL_BITS-1:0]    mul_q;
	logic [PROD_BITS-1:0]   prod_q;
	logic [NUM_BITS-1:0]    num_q;
	logic [REM_BITS-1:0]    hundred_q;
	logic [REM_BITS-1:0]    rem_q;
	logic [VB-1:0]          value_q;
	logic [VB-1:0]          res_value_q;
	logic [3*TB-1:0]        res_tubes_q;
	logic                   res_sat_q;

	logic [SAMPLE_BITS-1:0] zero;
	logic [SUM_EXT-1:0]     sum_ext;
	logic [SPLIT_BITS-1:0]  mul_a;
	logic [FULL_BITS-1:0]   full;
	logic [REM_BITS-1:0]    trial;
	logic                   ge;
	logic                   accept;

	assign accept  = item.valid && item.ready;
	assign zero    = SAMPLE_BITS'(cfg.zero_code);
	assign sum_ext = {1'b0, sum_q} + SUM_EXT'(sq_q);
	assign mul_a   = cmd.mul_hi ? SPLIT_BITS'(sum_q[SUM_BITS-1:SPLIT_BITS])
	                            : sum_q[SPLIT_BITS-1:0];
	// numerator of the mean: (prod * 2^shift + count * 2^31) / 2^32
	assign full    = (FULL_BITS'(prod_q) << msp_pkg::gain_shift(cfg.gain_mode))
	               + (FULL_BITS'(count_q) << msp_pkg::ROUND_SHIFT);
	assign trial   = REM_BITS'(count_q) << cmd.div_bit;
	assign ge      = rem_q >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q       <= '0;
			count_q     <= '0;
			ovf_q       <= 1'b0;
			test_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cmd.accum) begin
				if (sum_ext[SUM_BITS]) begin
					sum_q <= '1;
					ovf_q <= 1'b1;
				end else begin
					sum_q <= sum_ext[SUM_BITS-1:0];
				end
				if (count_q == '1)
					ovf_q <= 1'b1;
				else
					count_q <= count_q + 1'b1;
			end else if (cmd.finish) begin
				sum_q   <= '0;
				count_q <= '0;
				ovf_q   <= 1'b0;
			end

			if (cfg.test_restart)
				test_q <= '0;
			else if (cmd.finish && cfg.test_mode)
				test_q <= (test_q >= msp_pkg::DISPLAY_MAX) ? '0 : test_q + 1'b1;

			if (cmd.finish)
				res_valid_q <= 1'b1;
			else if (result.ready)
				res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tick_q <= item.req_type;
			hit_q  <= (item.sample_channel_id == cfg.sample_channel);
			diff_q <= (item.sample_code >= zero) ? item.sample_code - zero
			                                     : zero - item.sample_code;
		end
		if (cmd.square)
			sq_q <= SQ_BITS'(diff_q) * SQ_BITS'(diff_q);
		// one multiplier shared by both halves of the sum
		if (cmd.mul_lo || cmd.mul_hi)
			mul_q <= MUL_BITS'(mul_a) * MUL_BITS'(cfg.scale_q32);
		if (cmd.mul_hi)
			prod_q <= PROD_BITS'(mul_q);
		else if (cmd.combine)
			prod_q <= prod_q + (PROD_BITS'(mul_q) << SPLIT_BITS);
		if (cmd.scale) begin
			num_q     <= full[FULL_BITS-1:msp_pkg::FRAC_BITS];
			hundred_q <= REM_BITS'(count_q) * REM_BITS'(msp_pkg::DISPLAY_SPAN);
		end
		if (cmd.value_init)
			value_q <= cfg.test_mode ? test_q : '0;
		else if (cmd.check) begin
			value_q <= sts.over ? msp_pkg::DISPLAY_MAX : '0;
			rem_q   <= num_q[REM_BITS-1:0];
		end else if (cmd.div_step) begin
			value_q <= {value_q[VB-2:0], ge};
			if (ge)
				rem_q <= rem_q - trial;
		end
		if (cmd.finish) begin
			res_value_q <= value_q;
			res_tubes_q <= msp_pkg::tube_bytes(value_q);
			res_sat_q   <= ovf_q;
		end
	end

	always_comb begin
		sts.item_valid = item.valid;
		sts.is_tick    = tick_q;
		sts.chan_hit   = hit_q;
		sts.test_mode  = cfg.test_mode;
		sts.count_zero = (count_q == '0);
		sts.over       = num_q >= NUM_BITS'(hundred_q);
		sts.out_free   = !res_valid_q || result.ready;
	end

	assign item.ready             = cmd.take;
	assign result.valid           = res_valid_q;
	assign result.display_value   = res_value_q;
	assign result.tube_byte_one   = res_tubes_q[3*TB-1:2*TB];
	assign result.tube_byte_two   = res_tubes_q[2*TB-1:TB];
	assign result.tube_byte_three = res_tubes_q[TB-1:0];
	assign result.saturated       = res_sat_q;

	a_value_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> result.display_value <= msp_pkg::DISPLAY_MAX)
		else $error("display value above limit");

	a_tube_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> ($countones({result.tube_byte_one[7:1], result.tube_byte_two[3:1]}) == 1
			&& $countones({result.tube_byte_two[7:4], result.tube_byte_three[6:1]}) == 1))
		else $error("tube bytes not one digit each");

	a_clear_on_finish: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> (sum_q == '0 && count_q == '0 && !ovf_q))
		else $error("accumulators not cleared after result");

	a_div_not_over: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> rem_q < (trial << 1))
		else $error("division remainder out of range");

endmodule

>>> hw/rtl/mean_square_power_meter.sv
// Sample transaction: latched on accept, then squared and accumulated; the next one is
// taken only after that. A sample for another channel is dropped after latching.
// Tick transaction: two 21x20 partial products, their sum, gain and rounding, a range check,
// then a 7-step restoring division by the sample count; a result clamped to 99 skips the
// division, test mode or no samples skip all of it. A waiting result lets samples through.
// Async active-low reset restores register defaults and clears sum, count, flag, test counter.
module mean_square_power_meter #(
	parameter int SAMPLE_BITS = msp_pkg::SAMPLE_BITS_DEF,
	parameter int COUNT_BITS  = msp_pkg::COUNT_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [msp_pkg::APB_ADDR_BITS-1:0] paddr,
	input  logic [msp_pkg::APB_DATA_BITS-1:0] pwdata,
	output logic [msp_pkg::APB_DATA_BITS-1:0] prdata,
	output logic                              pready,
	msp_item_if.sink                          item,
	msp_result_if.source                      result
);

	msp_pkg::cfg_t cfg;
	msp_pkg::cmd_t cmd;
	msp_pkg::sts_t sts;

	msp_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	msp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	msp_dp #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.COUNT_BITS  (COUNT_BITS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.cmd    (cmd),
		.sts    (sts),
		.item   (item),
		.result (result)
	);

endmodule

>>> tb/tb_mean_square_power_meter.sv
`timescale 1ns / 1ps

module tb_mean_square_power_meter;

	localparam int PERIOD      = 8;
	localparam int QUIET_LIMIT = 2000;
	localparam int SETTLE      = 24;
	localparam int HOLD_CYCLES = 300;
	localparam int SUM_W       = 2 * msp_pkg::SAMPLE_BITS_DEF + msp_pkg::COUNT_BITS_DEF;

	localparam logic REQ_SAMPLE = 1'b0;
	localparam logic REQ_TICK   = 1'b1;

	localparam logic [msp_pkg::GAIN_BITS-1:0]    GAIN_X16      = 2'd2;
	localparam logic [msp_pkg::GAIN_BITS-1:0]    GAIN_X16_ALT  = 2'd3;
	localparam logic [msp_pkg::REG_IDX_BITS-1:0] REG_UNUSED_LO = 3'd5;
	localparam logic [msp_pkg::REG_IDX_BITS-1:0] REG_UNUSED_HI = 3'd7;

	localparam logic [msp_pkg::ZERO_BITS-1:0]      CODE_MAX   = '1;
	localparam logic [msp_pkg::SCALE_BITS-1:0]     SCALE_MAX  = '1;
	localparam logic [SUM_W-1:0]                   SUM_FULL   = '1;
	localparam logic [msp_pkg::COUNT_BITS_DEF-1:0] COUNT_FULL = '1;

	typedef struct packed {
		logic [msp_pkg::VALUE_BITS-1:0] value;
		logic [msp_pkg::TUBE_BITS-1:0]  tube1;
		logic [msp_pkg::TUBE_BITS-1:0]  tube2;
		logic [msp_pkg::TUBE_BITS-1:0]  tube3;
		logic                           sat;
	} reading_t;

	typedef struct packed {
		logic                          kind;
		logic [msp_pkg::CHAN_BITS-1:0] chan;
		logic [msp_pkg::ZERO_BITS-1:0] code;
		logic                          fixed;
		reading_t                      want;
	} step_t;

	localparam reading_t SHOW_ZERO  = '{7'd0, 8'h00, 8'h08, 8'h40, 1'b0};
	localparam reading_t SHOW_FULL  = '{7'd99, 8'h00, 8'h04, 8'h20, 1'b0};
	localparam reading_t NO_READING = '0;

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [msp_pkg::APB_ADDR_BITS-1:0] paddr;
	logic [msp_pkg::APB_DATA_BITS-1:0] pwdata;
	logic [msp_pkg::APB_DATA_BITS-1:0] prdata;
	logic pready;

	msp_item_if   item_bus ();
	msp_result_if res_bus ();

	mean_square_power_meter dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.item    (item_bus),
		.result  (res_bus)
	);

	always #(PERIOD / 2) clk = ~clk;

	// shadow registers and accumulators of the meter
	logic [msp_pkg::CHAN_BITS-1:0]      cfg_chan;
	logic [msp_pkg::ZERO_BITS-1:0]      cfg_zero;
	logic [msp_pkg::SCALE_BITS-1:0]     cfg_scale;
	logic [msp_pkg::GAIN_BITS-1:0]      cfg_gain;
	logic                               cfg_test;
	logic [SUM_W-1:0]                   acc_sum;
	logic [msp_pkg::COUNT_BITS_DEF-1:0] acc_count;
	logic                               acc_over;
	logic [msp_pkg::VALUE_BITS-1:0]     pattern;

	reading_t readings[$];
	int       mismatches;
	bit       gaps_on;
	bit       stalls_on;
	bit       hold_req;
	int       rx_wait;

	step_t script [25] = '{
		'{REQ_TICK,   3'd0, 12'd0,    1'b1, SHOW_ZERO},
		'{REQ_SAMPLE, 3'd5, 12'd2275, 1'b0, NO_READING},
		'{REQ_TICK,   3'd5, 12'd0,    1'b1, SHOW_ZERO},
		'{REQ_SAMPLE, 3'd5, 12'd0,    1'b0, NO_READING},
		'{REQ_SAMPLE, 3'd5, 12'd4095, 1'b0, NO_READING},
		'{REQ_TICK,   3'd7, 12'd4095, 1'b1, SHOW_FULL},
		'{REQ_SAMPLE, 3'd0, 12'd4095, 1'b0, NO_READING},
		'{REQ_SAMPLE, 3'd7, 12'd0,    1'b0, NO_READING},
		'{REQ_SAMPLE, 3'd4, 12'd0,    1'b0, NO_READING},
		'{REQ_TICK,   3'd5, 12'd2275, 1'b1, SHOW_ZERO},
		'{REQ_SAMPLE, 3'd5, 12'd2300, 1'b0, NO_READING},
		'{REQ_SAMPLE, 3'd5, 12'd2250, 1'b0, NO_READING},
		'{REQ_TICK,   3'd2, 12'd1365, 1'b0, NO_READING},
		'{REQ_SAMPLE, 3'd5, 12'd2475, 1'b0, NO_READING},
		'{REQ_TICK,   3'd5, 12'd2730, 1'b0, NO_READING},
		'{REQ_SAMPLE, 3'd5, 12'd3000, 1'b0, NO_READING},
		'{REQ_SAMPLE, 3'd5, 12'd1500, 1'b0, NO_READING},
		'{REQ_TICK,   3'd1, 12'd4095, 1'b0, NO_READING},
		'{REQ_SAMPLE, 3'd5, 12'd4095, 1'b0, NO_READING},
		'{REQ_TICK,   3'd6, 12'd0,    1'b1, SHOW_FULL},
		'{REQ_SAMPLE, 3'd5, 12'd2840, 1'b0, NO_READING},
		'{REQ_TICK,   3'd3, 12'd3276, 1'b0, NO_READING},
		'{REQ_SAMPLE, 3'd5, 12'd2048, 1'b0, NO_READING},
		'{REQ_SAMPLE, 3'd2, 12'd1234, 1'b0, NO_READING},
		'{REQ_TICK,   3'd5, 12'd2047, 1'b0, NO_READING}
	};

	// advance the accumulators by one transaction; returns 1 when a reading is due
	function automatic bit meter_predict(input logic kind,
			input logic [msp_pkg::CHAN_BITS-1:0] chan,
			input logic [msp_pkg::ZERO_BITS-1:0] code, output reading_t r);
		logic [msp_pkg::ZERO_BITS-1:0]  delta;
		logic [SUM_W-1:0]               sq;
		logic [127:0]                   num;
		logic [msp_pkg::VALUE_BITS-1:0] v;
		int                             sh;
		int                             tens;
		int                             ones;
		r = '0;
		if (kind == REQ_SAMPLE) begin
			if (chan != cfg_chan)
				return 1'b0;
			delta = (code >= cfg_zero) ? code - cfg_zero : cfg_zero - code;
			sq = SUM_W'(delta) * SUM_W'(delta);
			if (sq > SUM_FULL - acc_sum) begin
				acc_sum = SUM_FULL;
				acc_over = 1'b1;
			end else begin
				acc_sum = acc_sum + sq;
			end
			if (acc_count == COUNT_FULL)
				acc_over = 1'b1;
			else
				acc_count = acc_count + 1'b1;
			return 1'b0;
		end
		if (cfg_test) begin
			v = (pattern > msp_pkg::DISPLAY_MAX) ? msp_pkg::DISPLAY_MAX : pattern;
			pattern = (pattern >= msp_pkg::DISPLAY_MAX) ? '0 : pattern + 1'b1;
		end else if (acc_count == '0) begin
			v = '0;
		end else begin
			sh = (cfg_gain == msp_pkg::GAIN_X4) ? 2 : (cfg_gain == msp_pkg::GAIN_X8) ? 3 : 4;
			// sum * scale * factor, plus half a count for rounding, over count * 2^32
			num = (128'(acc_sum) * 128'(cfg_scale)) << sh;
			num = num + (128'(acc_count) << msp_pkg::ROUND_SHIFT);
			num = (num >> msp_pkg::FRAC_BITS) / 128'(acc_count);
			v = (num > 128'(msp_pkg::DISPLAY_MAX)) ? msp_pkg::DISPLAY_MAX
			                                       : num[msp_pkg::VALUE_BITS-1:0];
		end
		tens = int'(v) / 10;
		ones = int'(v) % 10;
		case (tens)
			0: r.tube2[3] = 1'b1;
			8: r.tube2[1] = 1'b1;
			9: r.tube2[2] = 1'b1;
			default: r.tube1[tens] = 1'b1;
		endcase
		if (ones == 0)
			r.tube3[6] = 1'b1;
		else if (ones <= 4)
			r.tube2[ones + 3] = 1'b1;
		else
			r.tube3[ones - 4] = 1'b1;
		r.value = v;
		r.sat = acc_over;
		acc_sum = '0;
		acc_count = '0;
		acc_over = 1'b0;
		return 1'b1;
	endfunction

	task automatic offer_item(input logic kind, input logic [msp_pkg::CHAN_BITS-1:0] chan,
			input logic [msp_pkg::ZERO_BITS-1:0] code);
		reading_t r;
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			item_bus.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		item_bus.valid <= 1'b1;
		item_bus.req_type <= kind;
		item_bus.sample_channel_id <= chan;
		item_bus.sample_code <= code;
		do @(posedge clk); while (!item_bus.ready);
		if (meter_predict(kind, chan, code, r))
			readings.push_back(r);
	endtask

	task automatic write_reg(input logic [msp_pkg::REG_IDX_BITS-1:0] idx,
			input logic [msp_pkg::APB_DATA_BITS-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			msp_pkg::REG_SAMPLE_CHANNEL: cfg_chan = data[msp_pkg::CHAN_BITS-1:0];
			msp_pkg::REG_ZERO_CODE:      cfg_zero = data[msp_pkg::ZERO_BITS-1:0];
			msp_pkg::REG_SCALE_Q32:      cfg_scale = data[msp_pkg::SCALE_BITS-1:0];
			msp_pkg::REG_GAIN_MODE:      cfg_gain = data[msp_pkg::GAIN_BITS-1:0];
			msp_pkg::REG_TEST_MODE: begin
				if (!cfg_test && data[0])
					pattern = '0;
				cfg_test = data[0];
			end
			default: ;
		endcase
		// idle cycle keeps back-to-back writes in separate time steps
		@(posedge clk);
	endtask

	task automatic retune(input logic [msp_pkg::CHAN_BITS-1:0] chan,
			input logic [msp_pkg::ZERO_BITS-1:0] zero,
			input logic [msp_pkg::SCALE_BITS-1:0] scale,
			input logic [msp_pkg::GAIN_BITS-1:0] gain,
			input logic test, input bit noisy);
		logic [msp_pkg::APB_DATA_BITS-1:0] junk;
		junk = noisy ? msp_pkg::APB_DATA_BITS'($urandom) : '0;
		write_reg(msp_pkg::REG_SAMPLE_CHANNEL,
			(junk << msp_pkg::CHAN_BITS) | msp_pkg::APB_DATA_BITS'(chan));
		write_reg(msp_pkg::REG_ZERO_CODE,
			(junk << msp_pkg::ZERO_BITS) | msp_pkg::APB_DATA_BITS'(zero));
		write_reg(msp_pkg::REG_SCALE_Q32,
			(junk << msp_pkg::SCALE_BITS) | msp_pkg::APB_DATA_BITS'(scale));
		write_reg(msp_pkg::REG_GAIN_MODE,
			(junk << msp_pkg::GAIN_BITS) | msp_pkg::APB_DATA_BITS'(gain));
		write_reg(msp_pkg::REG_TEST_MODE, (junk << 1) | msp_pkg::APB_DATA_BITS'(test));
	endtask

	task automatic retune_random();
		retune(msp_pkg::CHAN_BITS'($urandom), msp_pkg::ZERO_BITS'($urandom),
			msp_pkg::SCALE_BITS'($urandom) >> $urandom_range(0, 12),
			msp_pkg::GAIN_BITS'($urandom), $urandom_range(0, 4) == 0, 1'b1);
	endtask

	// wait out every pending reading plus the tail of a sample still in flight
	task automatic drain();
		item_bus.valid <= 1'b0;
		while (readings.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic traffic(input int n, input int tick_pct);
		logic                          kind;
		logic [msp_pkg::CHAN_BITS-1:0] chan;
		logic [msp_pkg::ZERO_BITS-1:0] code;
		int                            pick;
		int                            c;
		for (int i = 0; i < n; i++) begin
			kind = ($urandom_range(0, 99) < tick_pct) ? REQ_TICK : REQ_SAMPLE;
			chan = ($urandom_range(0, 9) < 8) ? cfg_chan : msp_pkg::CHAN_BITS'($urandom);
			pick = $urandom_range(0, 9);
			if (pick == 0) begin
				code = '0;
			end else if (pick == 1) begin
				code = CODE_MAX;
			end else if (pick < 5) begin
				// stay near the zero code so readings land below the clamp
				c = int'(cfg_zero) + int'($urandom_range(0, 160)) - 80;
				code = (c < 0) ? '0 : (c > int'(CODE_MAX)) ? CODE_MAX
				                                           : msp_pkg::ZERO_BITS'(c);
			end else begin
				code = msp_pkg::ZERO_BITS'($urandom);
			end
			offer_item(kind, chan, code);
		end
	endtask

	initial begin
		res_bus.ready = 1'b0;
		rx_wait = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				rx_wait = HOLD_CYCLES;
			end else if (rx_wait == 0 && stalls_on && $urandom_range(0, 5) == 0) begin
				rx_wait = $urandom_range(1, 3);
			end
			if (rx_wait > 0) begin
				rx_wait--;
				res_bus.ready <= 1'b0;
			end else begin
				res_bus.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : check_readings
		reading_t got;
		reading_t want;
		if (arst_n && res_bus.valid && res_bus.ready) begin
			got = '{res_bus.display_value, res_bus.tube_byte_one, res_bus.tube_byte_two,
				res_bus.tube_byte_three, res_bus.saturated};
			if (readings.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected reading: %0d tubes %h %h %h sat %b", got.value,
						got.tube1, got.tube2, got.tube3, got.sat);
			end else begin
				want = readings.pop_front();
				if (got.value !== want.value || got.tube1 !== want.tube1
						|| got.tube2 !== want.tube2 || got.tube3 !== want.tube3
						|| got.sat !== want.sat) begin
					mismatches++;
					if (mismatches <= 10)
						$display("reading mismatch: expected %0d %h %h %h %b, got %0d %h %h %h %b",
							want.value, want.tube1, want.tube2, want.tube3, want.sat,
							got.value, got.tube1, got.tube2, got.tube3, got.sat);
				end
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		@(posedge arst_n);
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((item_bus.valid && item_bus.ready) || (res_bus.valid && res_bus.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("tb: failure");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		item_bus.valid = 1'b0;
		item_bus.req_type = REQ_SAMPLE;
		item_bus.sample_channel_id = '0;
		item_bus.sample_code = '0;
		cfg_chan = msp_pkg::RST_SAMPLE_CHANNEL;
		cfg_zero = msp_pkg::RST_ZERO_CODE;
		cfg_scale = msp_pkg::RST_SCALE_Q32;
		cfg_gain = msp_pkg::RST_GAIN_MODE;
		cfg_test = 1'b0;
		acc_sum = '0;
		acc_count = '0;
		acc_over = 1'b0;
		pattern = '0;
		mismatches = 0;
		gaps_on = 1'b1;
		stalls_on = 1'b1;
		hold_req = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < $size(script); i++) begin
			offer_item(script[i].kind, script[i].chan, script[i].code);
			if (script[i].fixed)
				readings[readings.size() - 1] = script[i].want;
		end

		// register extremes; gain mode three acts as sixteen
		drain();
		retune(3'd0, '0, SCALE_MAX, GAIN_X16_ALT, 1'b0, 1'b0);
		write_reg(REG_UNUSED_LO, '1);
		write_reg(REG_UNUSED_HI, 32'h1234_5678);
		traffic(120, 10);
		drain();
		retune(3'd7, CODE_MAX, '0, msp_pkg::GAIN_X8, 1'b0, 1'b0);
		traffic(120, 10);
		drain();
		retune(3'd3, 12'd2048, 20'd60000, GAIN_X16, 1'b0, 1'b0);
		traffic(60, 10);

		// test pattern: run past the wrap, then rewrite, drop and restart it
		drain();
		write_reg(msp_pkg::REG_TEST_MODE, 32'd1);
		traffic(230, 50);
		drain();
		write_reg(msp_pkg::REG_TEST_MODE, 32'd1);
		traffic(20, 50);
		drain();
		write_reg(msp_pkg::REG_TEST_MODE, 32'd0);
		traffic(20, 30);
		drain();
		write_reg(msp_pkg::REG_TEST_MODE, 32'd1);
		traffic(20, 50);

		for (int p = 0; p < 6; p++) begin
			drain();
			retune_random();
			traffic(100, 10);
		end

		// hold the result side off so finished ticks back up into the input
		drain();
		retune_random();
		hold_req = 1'b1;
		traffic(60, 40);

		drain();
		retune_random();
		gaps_on = 1'b0;
		stalls_on = 1'b0;
		traffic(150, 10);

		item_bus.valid <= 1'b0;
		while (readings.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
